/* rtl/core/at_rtd_pkg.sv */
// Package for the modem response terminator detector.
// Holds field widths, kind/status/pattern codes, the terminator table and
// the result struct. No dependencies.
package at_rtd_pkg;

  localparam int WINDOW_BYTES   = 17;
  localparam int RESPONSE_BYTES = 256;

  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int PAT_W    = 3;
  localparam int COUNT_W  = 8;
  localparam int MAXLEN_W = 8;
  localparam int TIMER_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] LIMIT_CAP  = COUNT_W'(RESPONSE_BYTES - 1);
  localparam logic [TIMER_W-1:0] TIMER_MAX  = '1;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RST = 8'd255;
  localparam logic [TIMER_W-1:0]  TIMEOUT_RST = 16'd1500;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 1'd1;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_COLLECTING = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TERMINAL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TMO_DATA   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TMO_EMPTY  = 3'd4;

  localparam logic [PAT_W-1:0] PAT_NONE = 3'd0;

  // Terminator table, right aligned: byte 0 is the last character.
  localparam int PAT_COUNT   = 7;
  localparam int PAT_MAX_LEN = 17;
  typedef logic [PAT_MAX_LEN-1:0][BYTE_W-1:0] pat_text_t;
  localparam pat_text_t PAT_TEXT [PAT_COUNT] = '{
    pat_text_t'("OK\r\n"),
    pat_text_t'("ERROR"),
    pat_text_t'("FAIL"),
    pat_text_t'("WIFI GOT IP"),
    pat_text_t'("SEND OK"),
    pat_text_t'("ALREADY CONNECTED"),
    pat_text_t'(">")
  };
  localparam int PAT_LEN [PAT_COUNT] = '{4, 5, 4, 11, 7, 17, 1};

  typedef logic [WINDOW_BYTES-1:0][BYTE_W-1:0] window_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAT_W-1:0]    which_pattern;
    logic [COUNT_W-1:0]  stored_count;
  } result_t;

endpackage

/* rtl/core/at_rtd_if.sv */
// Channel interfaces of the terminator detector: input beats and result beats.
// Depends on at_rtd_pkg.
interface at_rtd_in_if;
  logic                            valid;
  logic                            ready;
  logic [at_rtd_pkg::KIND_W-1:0]   kind;
  logic [at_rtd_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink (input valid, kind, rx_byte, output ready);
endinterface

interface at_rtd_out_if;
  logic                              valid;
  logic                              ready;
  logic [at_rtd_pkg::STATUS_W-1:0]   status;
  logic [at_rtd_pkg::PAT_W-1:0]      which_pattern;
  logic [at_rtd_pkg::COUNT_W-1:0]    stored_count;

  modport source (output valid, status, which_pattern, stored_count, input ready);
  modport sink (input valid, status, which_pattern, stored_count, output ready);
endinterface

/* rtl/core/at_rtd_match.sv */
// Parallel terminator compare over the tail window, lowest code wins.
// Depends on at_rtd_pkg.
module at_rtd_match (
  input  at_rtd_pkg::window_t            window,
  output logic [at_rtd_pkg::PAT_W-1:0]   code
);

  logic [at_rtd_pkg::PAT_COUNT-1:0] hit;

  always_comb begin
    for (int p = 0; p < at_rtd_pkg::PAT_COUNT; p++) begin
      hit[p] = 1'b1;
      for (int i = 0; i < at_rtd_pkg::PAT_MAX_LEN; i++) begin
        if (i < at_rtd_pkg::PAT_LEN[p] && window[i] != at_rtd_pkg::PAT_TEXT[p][i]) begin
          hit[p] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    code = at_rtd_pkg::PAT_NONE;
    // scan from the back so the lowest index is left standing
    for (int p = at_rtd_pkg::PAT_COUNT - 1; p >= 0; p--) begin
      if (hit[p]) begin
        code = at_rtd_pkg::PAT_W'(p + 1);
      end
    end
  end

endmodule

/* rtl/core/at_rtd_ctrl.sv */
// Response state: config registers, tail window, count, timer and end flags.
// Computes the result of each accepted beat. Depends on at_rtd_pkg, at_rtd_match.
module at_rtd_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [at_rtd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [at_rtd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                accept,
  input  logic [at_rtd_pkg::KIND_W-1:0]       kind,
  input  logic [at_rtd_pkg::BYTE_W-1:0]       rx_byte,
  output at_rtd_pkg::result_t                 res_next
);

  logic [at_rtd_pkg::MAXLEN_W-1:0] max_length;
  logic [at_rtd_pkg::TIMER_W-1:0]  timeout_ms;

  at_rtd_pkg::window_t              window, window_next, window_shift;
  logic [at_rtd_pkg::COUNT_W-1:0]   byte_count, byte_count_next, count_inc;
  logic [at_rtd_pkg::TIMER_W-1:0]   elapsed_ms, elapsed_ms_next, elapsed_inc;
  logic                             finished, finished_next;
  logic                             nul_seen, nul_seen_next, nul_after;
  logic [at_rtd_pkg::STATUS_W-1:0]  final_status, final_status_next, tmo_status;
  logic [at_rtd_pkg::PAT_W-1:0]     final_pattern, final_pattern_next;
  logic [at_rtd_pkg::PAT_W-1:0]     match_code;
  logic [at_rtd_pkg::COUNT_W-1:0]   limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= at_rtd_pkg::MAXLEN_RST;
      timeout_ms <= at_rtd_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        at_rtd_pkg::CFG_MAX_LENGTH: max_length <= cfg_data[at_rtd_pkg::MAXLEN_W-1:0];
        at_rtd_pkg::CFG_TIMEOUT_MS: timeout_ms <= cfg_data[at_rtd_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit = (at_rtd_pkg::COUNT_W'(max_length) > at_rtd_pkg::LIMIT_CAP) ?
                 at_rtd_pkg::LIMIT_CAP : at_rtd_pkg::COUNT_W'(max_length);

  assign window_shift = {window[at_rtd_pkg::WINDOW_BYTES-2:0], rx_byte};
  assign count_inc    = byte_count + 1'b1;
  assign nul_after    = nul_seen | (rx_byte == '0);
  assign elapsed_inc  = (elapsed_ms == at_rtd_pkg::TIMER_MAX) ? elapsed_ms : elapsed_ms + 1'b1;
  assign tmo_status   = (byte_count != '0) ? at_rtd_pkg::ST_TMO_DATA
                                           : at_rtd_pkg::ST_TMO_EMPTY;

  at_rtd_match u_match (
    .window (window_shift),
    .code   (match_code)
  );

  always_comb begin
    window_next        = window;
    byte_count_next    = byte_count;
    elapsed_ms_next    = elapsed_ms;
    finished_next      = finished;
    nul_seen_next      = nul_seen;
    final_status_next  = final_status;
    final_pattern_next = final_pattern;
    case (kind)
      at_rtd_pkg::KIND_START: begin
        window_next        = '0;
        byte_count_next    = '0;
        elapsed_ms_next    = '0;
        finished_next      = 1'b0;
        nul_seen_next      = 1'b0;
        final_status_next  = at_rtd_pkg::ST_COLLECTING;
        final_pattern_next = at_rtd_pkg::PAT_NONE;
      end
      at_rtd_pkg::KIND_BYTE: begin
        if (!finished) begin
          if (elapsed_ms >= timeout_ms) begin
            finished_next     = 1'b1;
            final_status_next = tmo_status;
          end else if (byte_count >= limit) begin
            finished_next     = 1'b1;
            final_status_next = at_rtd_pkg::ST_FULL;
          end else begin
            window_next     = window_shift;
            byte_count_next = count_inc;
            nul_seen_next   = nul_after;
            // a zero byte ends the string: no match from here on
            if (!nul_after && match_code != at_rtd_pkg::PAT_NONE) begin
              finished_next      = 1'b1;
              final_status_next  = at_rtd_pkg::ST_TERMINAL;
              final_pattern_next = match_code;
            end else if (count_inc >= limit) begin
              finished_next     = 1'b1;
              final_status_next = at_rtd_pkg::ST_FULL;
            end
          end
        end
      end
      at_rtd_pkg::KIND_TICK: begin
        if (!finished) begin
          elapsed_ms_next = elapsed_inc;
          if (elapsed_inc >= timeout_ms) begin
            finished_next     = 1'b1;
            final_status_next = tmo_status;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      byte_count    <= '0;
      elapsed_ms    <= '0;
      finished      <= 1'b0;
      nul_seen      <= 1'b0;
      final_status  <= at_rtd_pkg::ST_COLLECTING;
      final_pattern <= at_rtd_pkg::PAT_NONE;
    end else if (accept) begin
      window        <= window_next;
      byte_count    <= byte_count_next;
      elapsed_ms    <= elapsed_ms_next;
      finished      <= finished_next;
      nul_seen      <= nul_seen_next;
      final_status  <= final_status_next;
      final_pattern <= final_pattern_next;
    end
  end

  always_comb begin
    res_next.status        = finished_next ? final_status_next : at_rtd_pkg::ST_COLLECTING;
    res_next.which_pattern = finished_next ? final_pattern_next : at_rtd_pkg::PAT_NONE;
    res_next.stored_count  = byte_count_next;
  end

endmodule

/* rtl/core/at_response_terminator_detect_core.sv */
// Top level of the modem response terminator detector: handshake and result register.
// Depends on at_rtd_pkg, at_rtd_if, at_rtd_ctrl.
//
//   channel  dir  payload                              beat
//   rx_in    in   kind[1:0], rx_byte[7:0]              valid && ready
//   res_out  out  status[2:0], which_pattern[2:0],     valid && ready
//                 stored_count[7:0]
//   cfg      in   cfg_we, cfg_index[0], cfg_data[15:0] cfg_we
//
// One input beat per cycle unless res_out stalls; each beat gives one result beat on
// the next cycle, set by the combinational window compare from state into result register.
// Synchronous reset restores max_length 255, timeout_ms 1500, clears state but res.
// While the result register holds an untaken beat, rx_in.ready follows res_out.ready.
module at_response_terminator_detect_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [at_rtd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [at_rtd_pkg::CFG_DATA_W-1:0]   cfg_data,
  at_rtd_in_if.sink                           rx_in,
  at_rtd_out_if.source                        res_out
);

  logic                 accept;
  logic                 out_valid;
  at_rtd_pkg::result_t  res_next;
  at_rtd_pkg::result_t  res;

  assign rx_in.ready = !out_valid || res_out.ready;
  assign accept      = rx_in.valid && rx_in.ready;

  at_rtd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (rx_in.kind),
    .rx_byte   (rx_in.rx_byte),
    .res_next  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_in.ready) begin
      out_valid <= rx_in.valid;
    end
  end

  // load only on an accepted beat; hold while the sink stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign res_out.valid         = out_valid;
  assign res_out.status        = res.status;
  assign res_out.which_pattern = res.which_pattern;
  assign res_out.stored_count  = res.stored_count;

endmodule
